[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, clocked on clk_i and gated by rst_ni.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define RDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset
`define RDC_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define RDC_ASSERT(label, prop, msg)
`define RDC_ASSERT_NEVER(label, expr, msg)

`endif

`endif

[design/rdc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rdc_pkg
// Shared types, constants and helpers for the radix digit converter.
// ---------------------------------------------------------------------------
package rdc_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 31;
  localparam int unsigned MAX_DIGITS_DEF  = 32;

  localparam int unsigned RADIX_WIDTH = 5;
  localparam int unsigned DIGIT_WIDTH = 4;
  localparam int unsigned CHAR_WIDTH  = 7;

  localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO     = 7'd48;  // '0'
  localparam logic [CHAR_WIDTH-1:0]  ALPHA_OFFSET  = 7'd55;  // 'A' - 10
  localparam logic [DIGIT_WIDTH-1:0] DECIMAL_LIMIT = 4'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_EMIT
  } rdc_state_e;

  // Control from the sequencer to the serial divider
  typedef struct packed {
    logic load;   // take a fresh value and radix, start a pass
    logic again;  // start another pass on the held quotient
  } rdc_div_ctl_t;

  // Status from the serial divider
  typedef struct packed {
    logic                   done;     // one-cycle pulse, pass finished
    logic [DIGIT_WIDTH-1:0] digit;    // remainder of the pass
    logic                   quot_nz;  // quotient of the pass is non-zero
  } rdc_div_sts_t;

  function automatic logic [RADIX_WIDTH-1:0] clamp_radix(
    input logic [RADIX_WIDTH-1:0] r
  );
    logic [RADIX_WIDTH-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] ascii_of(
    input logic [DIGIT_WIDTH-1:0] d
  );
    logic [CHAR_WIDTH-1:0] res;
    if (d < DECIMAL_LIMIT) begin
      res = CHAR_WIDTH'(d) + CHAR_ZERO;
    end else begin
      res = CHAR_WIDTH'(d) + ALPHA_OFFSET;
    end
    return res;
  endfunction

endpackage

[design/rdc_divider.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rdc_divider
// Bit-serial restoring divider: one quotient bit per cycle, quotient shifts
// back into the dividend register, narrow remainder.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rdc_divider #(
  parameter int unsigned VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rdc_pkg::rdc_div_ctl_t                 ctl_i,
  input  logic [VALUE_WIDTH-1:0]                value_i,
  input  logic [rdc_pkg::RADIX_WIDTH-1:0]       radix_i,
  output rdc_pkg::rdc_div_sts_t                 sts_o
);

  localparam int unsigned CW = $clog2(VALUE_WIDTH);

  logic                                 active_q, active_d;
  logic                                 done_q, done_d;
  logic [CW-1:0]                        cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0]               quot_q, quot_d;
  logic [rdc_pkg::DIGIT_WIDTH-1:0]      rem_q, rem_d;
  logic [rdc_pkg::RADIX_WIDTH-1:0]      rad_q, rad_d;
  logic                                 nz_q, nz_d;

  logic [rdc_pkg::RADIX_WIDTH-1:0]      trial;
  logic                                 ge;

  // Trial subtract of the shifted remainder
  assign trial = {rem_q, quot_q[VALUE_WIDTH-1]};
  assign ge    = (trial >= rad_q);

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    quot_d   = quot_q;
    rem_d    = rem_q;
    rad_d    = rad_q;
    nz_d     = nz_q;
    if (ctl_i.load || ctl_i.again) begin
      active_d = 1'b1;
      cnt_d    = CW'(VALUE_WIDTH - 1);
      rem_d    = '0;
      nz_d     = 1'b0;
      if (ctl_i.load) begin
        quot_d = value_i;
        rad_d  = radix_i;
      end
    end else if (active_q) begin
      quot_d = {quot_q[VALUE_WIDTH-2:0], ge};
      rem_d  = ge ? rdc_pkg::DIGIT_WIDTH'(trial - rad_q)
                  : trial[rdc_pkg::DIGIT_WIDTH-1:0];
      nz_d   = nz_q | ge;
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      quot_q   <= '0;
      rad_q    <= rdc_pkg::RADIX_MIN;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
      quot_q   <= quot_d;
      rad_q    <= rad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nz_q  <= nz_d;
  end

  assign sts_o.done    = done_q;
  assign sts_o.digit   = rem_q;
  assign sts_o.quot_nz = nz_q;

  // Assertions
  `RDC_ASSERT(a_start_idle, (ctl_i.load || ctl_i.again) |-> !active_q, "pass started while busy")
  `RDC_ASSERT(a_done_after_last, done_q |-> ($past(active_q) && $past(cnt_q) == '0), "done without final step")
  `RDC_ASSERT(a_rem_bound, (active_q || done_q) |-> ({1'b0, rem_q} < rad_q), "remainder not below radix")

endmodule

[design/radix_digit_converter.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// radix_digit_converter
// Converts a non-negative integer to its digits in radix 2..16, emitted most
// significant first as value, ASCII character and a last-digit flag.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one beat: value and radix.
//   A radix below 2 is taken as 2, above 16 as 16.
//   Output channel (out_valid_o / out_stall_i) gives one beat per digit,
//   most significant first; last_digit_o marks the least significant one.
//   Zero gives the single digit '0'.
// Timing:
//   Each digit costs one bit-serial division pass (one quotient bit per
//   cycle through the shared divider). Emission reads the digit store at
//   one address per beat.
//   Only one item is in work at a time; in_stall_o is high until the last
//   digit has moved into the output register, so the next item is taken
//   while that beat still waits.
// Reset: asynchronous, active low; clears the sequencer and output valid.
//   The digit store is not cleared: every entry read was written first.
// Stalls: the output register holds its beat while out_stall_i is high;
//   emission pauses, the divider work is already complete.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module radix_digit_converter #(
  parameter int unsigned VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned MAX_DIGITS  = rdc_pkg::MAX_DIGITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [VALUE_WIDTH-1:0]             value_i,
  input  logic [rdc_pkg::RADIX_WIDTH-1:0]    radix_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [rdc_pkg::DIGIT_WIDTH-1:0]    digit_value_o,
  output logic [rdc_pkg::CHAR_WIDTH-1:0]     digit_char_o,
  output logic                               last_digit_o
);

  localparam int unsigned AW = $clog2(MAX_DIGITS);      // store address
  localparam int unsigned NW = $clog2(MAX_DIGITS + 1);  // digit count

  rdc_pkg::rdc_state_e state_q, state_d;

  logic [NW-1:0] count_q, count_d;   // digits stored so far
  logic [NW-1:0] count_inc;
  logic [AW-1:0] idx_q, idx_d;       // emission index, counts down

  rdc_pkg::rdc_div_ctl_t div_ctl;
  rdc_pkg::rdc_div_sts_t div_sts;

  logic in_beat;
  logic more_digits;
  logic out_free;
  logic out_load;
  logic st_write;
  logic st_read;

  // Digit store
  logic [rdc_pkg::DIGIT_WIDTH-1:0] store_mem [MAX_DIGITS];
  logic [rdc_pkg::DIGIT_WIDTH-1:0] rd_data_q;

  // Output register
  logic                            out_valid_q, out_valid_d;
  logic [rdc_pkg::DIGIT_WIDTH-1:0] out_value_q;
  logic [rdc_pkg::CHAR_WIDTH-1:0]  out_char_q;
  logic                            out_last_q;

  assign in_beat     = in_valid_i && !in_stall_o;
  assign count_inc   = count_q + NW'(1);
  // Another pass needed if the quotient is non-zero and the store has room
  assign more_digits = div_sts.quot_nz && (count_inc < NW'(MAX_DIGITS));
  assign out_free    = !out_valid_q || !out_stall_i;

  rdc_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (div_ctl),
    .value_i (value_i),
    .radix_i (rdc_pkg::clamp_radix(radix_i)),
    .sts_o   (div_sts)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rdc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = rdc_pkg::ST_DIV;
        end
      end
      rdc_pkg::ST_DIV: begin
        if (div_sts.done && !more_digits) begin
          state_d = rdc_pkg::ST_READ;
        end
      end
      rdc_pkg::ST_READ: begin
        state_d = rdc_pkg::ST_EMIT;
      end
      rdc_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = (idx_q == '0) ? rdc_pkg::ST_IDLE : rdc_pkg::ST_READ;
        end
      end
      default: begin
        state_d = rdc_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall_o    = 1'b1;
    div_ctl.load  = 1'b0;
    div_ctl.again = 1'b0;
    st_write      = 1'b0;
    st_read       = 1'b0;
    out_load      = 1'b0;
    count_d       = count_q;
    idx_d         = idx_q;
    case (state_q)
      rdc_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        div_ctl.load = in_valid_i;
        if (in_valid_i) begin
          count_d = '0;
        end
      end
      rdc_pkg::ST_DIV: begin
        if (div_sts.done) begin
          st_write      = 1'b1;
          count_d       = count_inc;
          div_ctl.again = more_digits;
          // most significant digit sits at the highest written address
          idx_d         = count_q[AW-1:0];
        end
      end
      rdc_pkg::ST_READ: begin
        st_read = 1'b1;
      end
      rdc_pkg::ST_EMIT: begin
        out_load = out_free;
        if (out_free && idx_q != '0) begin
          idx_d = idx_q - AW'(1);
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdc_pkg::ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (st_write) begin
      store_mem[count_q[AW-1:0]] <= div_sts.digit;
    end
    if (st_read) begin
      rd_data_q <= store_mem[idx_q];
    end
  end

  // Output register, parts the sequencer from the receiver
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= rd_data_q;
      out_char_q  <= rdc_pkg::ascii_of(rd_data_q);
      out_last_q  <= (idx_q == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digit_value_o = out_value_q;
  assign digit_char_o  = out_char_q;
  assign last_digit_o  = out_last_q;

  // Assertions
  `RDC_ASSERT(a_done_in_div, div_sts.done |-> (state_q == rdc_pkg::ST_DIV), "divider done outside division")
  `RDC_ASSERT(a_count_bound, count_q <= NW'(MAX_DIGITS), "digit count beyond store depth")
  `RDC_ASSERT(a_last_quiet, (out_valid_o && !out_stall_i && last_digit_o) |=> !out_valid_o, "beat after last digit")
  `RDC_ASSERT(a_accept_idle, in_beat |=> (state_q == rdc_pkg::ST_DIV), "accepted item not in division")

endmodule
